>>> rtl/lpsd_pkg.sv
// lpsd_pkg: shared types and constants for the length-prefixed session deframer
// holds framing phases, parse modes, result kinds and packet type codes
// no dependencies
`default_nettype none

package lpsd_pkg;

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_BODY
  } phase_e;

  // space skip, active (digits for A, forwarding for S), done
  typedef enum logic [1:0] {
    PM_SPACE,
    PM_ACTIVE,
    PM_DONE
  } parse_mode_e;

  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_ACCEPT  = 3'd1;
  localparam logic [2:0] K_REJECT  = 3'd2;
  localparam logic [2:0] K_END     = 3'd3;
  localparam logic [2:0] K_UNKNOWN = 3'd4;

  localparam logic [7:0] TYPE_ACCEPT    = 8'h41;  // 'A'
  localparam logic [7:0] TYPE_HEARTBEAT = 8'h48;  // 'H'
  localparam logic [7:0] TYPE_REJECT    = 8'h4a;  // 'J'
  localparam logic [7:0] TYPE_SEQUENCED = 8'h53;  // 'S'
  localparam logic [7:0] TYPE_END       = 8'h5a;  // 'Z'

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // sequenced packets with fewer body bytes than this forward nothing
  localparam logic [15:0] MIN_FWD_LEFT = 16'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [63:0] seq;
    logic        connected;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/length_prefixed_session_deframer_top.sv
// length_prefixed_session_deframer_top: session packet deframer, one byte per beat
// depends on lpsd_pkg for phases, result kinds and packet type codes
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_byte_i) carries the raw server
//   stream: 2-byte big-endian length, type byte, body. one byte is taken at each
//   edge where in_valid_i is high and in_stall_o is low.
//   output channel (out_valid_o / out_stall_i / out_*_o) carries at most one
//   result per input byte: payload bytes of S packets, login accept/reject,
//   end of session, or an unknown type byte.
//   a result is registered in the output buffer when the byte that causes it is taken.
//   throughput: one byte per cycle while in_stall_o is low; all framing and
//   decimal parsing is done in a single pass of logic in front of the state registers.
//   a two-entry output buffer (output register plus skid register) lets a byte
//   be taken while a result waits; in_stall_o rises only once both entries
//   hold results, i.e. after the receiver has stalled with one result pending
//   and another arrived.
//   reset: expecting a length high byte, sequence number 0, not connected,
//   output buffer empty.
`default_nettype none

module length_prefixed_session_deframer_top #(
  parameter int SEQ_FIELD_BYTES     = 20,
  parameter int SESSION_FIELD_BYTES = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [63:0]      out_seq_o,
  output logic             out_connected_o
);

  localparam int OfsEnd = SESSION_FIELD_BYTES + SEQ_FIELD_BYTES;
  localparam int OfsW   = $clog2(OfsEnd + 1);
  localparam logic [OfsW-1:0] OfsSessionEnd = OfsW'(SESSION_FIELD_BYTES);
  localparam logic [OfsW-1:0] OfsFieldEnd   = OfsW'(OfsEnd);

  lpsd_pkg::phase_e      phase_q, phase_d;
  lpsd_pkg::parse_mode_e mode_q, mode_d;
  logic [7:0]            len_hi_q, len_hi_d;
  logic [15:0]           left_q, left_d;
  logic [OfsW-1:0]       ofs_q, ofs_d;
  logic [7:0]            type_q, type_d;
  logic [63:0]           acc_q, acc_d;
  logic [63:0]           seq_q, seq_d;
  logic                  conn_q, conn_d;

  logic                  in_accept;
  logic                  res_valid;
  logic [2:0]            res_kind;
  logic [7:0]            res_data;
  logic                  res_last;
  lpsd_pkg::result_t     res;

  logic                  out_valid_q, skid_valid_q;
  lpsd_pkg::result_t     out_q, skid_q;

  logic [67:0]           acc_next;
  logic                  acc_ovf;
  logic                  is_digit;
  logic                  finish;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = skid_valid_q;

  // acc * 10 + digit, overflow when it no longer fits in 64 bits
  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {64'b0, in_byte_i[3:0]};
  assign acc_ovf  = |acc_next[67:64];
  assign is_digit = (in_byte_i >= lpsd_pkg::CHAR_ZERO) && (in_byte_i <= lpsd_pkg::CHAR_NINE);

  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    len_hi_d  = len_hi_q;
    left_d    = left_q;
    ofs_d     = ofs_q;
    type_d    = type_q;
    acc_d     = acc_q;
    seq_d     = seq_q;
    conn_d    = conn_q;
    res_valid = 1'b0;
    res_kind  = lpsd_pkg::K_PAYLOAD;
    res_data  = 8'd0;
    res_last  = 1'b0;
    finish    = 1'b0;

    if (in_accept) begin
      unique case (phase_q)
        lpsd_pkg::PH_LEN_HI: begin
          len_hi_d = in_byte_i;
          phase_d  = lpsd_pkg::PH_LEN_LO;
        end
        lpsd_pkg::PH_LEN_LO: begin
          left_d  = {len_hi_q, in_byte_i};
          // zero-length packets have no type byte
          phase_d = ({len_hi_q, in_byte_i} == 16'd0) ? lpsd_pkg::PH_LEN_HI
                                                      : lpsd_pkg::PH_TYPE;
        end
        lpsd_pkg::PH_TYPE: begin
          type_d = in_byte_i;
          left_d = left_q - 16'd1;
          ofs_d  = '0;
          acc_d  = '0;
          mode_d = lpsd_pkg::PM_SPACE;
          if (in_byte_i == lpsd_pkg::TYPE_SEQUENCED) begin
            seq_d  = seq_q + 64'd1;
            mode_d = (left_d >= lpsd_pkg::MIN_FWD_LEFT) ? lpsd_pkg::PM_ACTIVE
                                                        : lpsd_pkg::PM_SPACE;
          end else if (in_byte_i != lpsd_pkg::TYPE_ACCEPT &&
                       in_byte_i != lpsd_pkg::TYPE_REJECT &&
                       in_byte_i != lpsd_pkg::TYPE_END &&
                       in_byte_i != lpsd_pkg::TYPE_HEARTBEAT) begin
            res_valid = 1'b1;
            res_kind  = lpsd_pkg::K_UNKNOWN;
            res_data  = in_byte_i;
          end
          if (left_d == 16'd0) begin
            phase_d = lpsd_pkg::PH_LEN_HI;
            finish  = !res_valid;
          end else begin
            phase_d = lpsd_pkg::PH_BODY;
          end
        end
        lpsd_pkg::PH_BODY: begin
          left_d = left_q - 16'd1;
          if (type_q == lpsd_pkg::TYPE_SEQUENCED) begin
            if (mode_q == lpsd_pkg::PM_ACTIVE) begin
              res_valid = 1'b1;
              res_kind  = lpsd_pkg::K_PAYLOAD;
              res_data  = in_byte_i;
              res_last  = (left_d == 16'd0);
            end
          end else if (type_q == lpsd_pkg::TYPE_ACCEPT) begin
            if (ofs_q >= OfsSessionEnd && ofs_q < OfsFieldEnd) begin
              if (mode_q == lpsd_pkg::PM_SPACE) begin
                if (in_byte_i != lpsd_pkg::CHAR_SPACE) begin
                  mode_d = lpsd_pkg::PM_ACTIVE;
                end
              end
              if (mode_d == lpsd_pkg::PM_ACTIVE) begin
                if (!is_digit) begin
                  mode_d = lpsd_pkg::PM_DONE;
                end else if (acc_ovf) begin
                  acc_d  = '1;
                  mode_d = lpsd_pkg::PM_DONE;
                end else begin
                  acc_d = acc_next[63:0];
                end
              end
            end
          end else if (type_q == lpsd_pkg::TYPE_REJECT) begin
            if (ofs_q == '0) begin
              acc_d = {56'd0, in_byte_i};
            end
          end
          // offset only matters up to the end of the sequence field
          if (ofs_q != OfsFieldEnd) begin
            ofs_d = ofs_q + OfsW'(1);
          end
          if (left_d == 16'd0) begin
            phase_d = lpsd_pkg::PH_LEN_HI;
            finish  = !res_valid;
          end
        end
        default: begin
          phase_d = lpsd_pkg::PH_LEN_HI;
        end
      endcase

      // end of packet report for A, J and Z
      if (finish) begin
        if (type_d == lpsd_pkg::TYPE_ACCEPT) begin
          seq_d     = acc_d;
          conn_d    = 1'b1;
          res_valid = 1'b1;
          res_kind  = lpsd_pkg::K_ACCEPT;
        end else if (type_d == lpsd_pkg::TYPE_REJECT) begin
          res_valid = 1'b1;
          res_kind  = lpsd_pkg::K_REJECT;
          res_data  = acc_d[7:0];
        end else if (type_d == lpsd_pkg::TYPE_END) begin
          conn_d    = 1'b0;
          res_valid = 1'b1;
          res_kind  = lpsd_pkg::K_END;
        end
      end
    end
  end

  assign res = '{kind: res_kind, data: res_data, last: res_last,
                 seq: seq_d, connected: conn_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lpsd_pkg::PH_LEN_HI;
      mode_q   <= lpsd_pkg::PM_SPACE;
      len_hi_q <= '0;
      left_q   <= '0;
      ofs_q    <= '0;
      type_q   <= '0;
      acc_q    <= '0;
      seq_q    <= '0;
      conn_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      ofs_q    <= ofs_d;
      type_q   <= type_d;
      acc_q    <= acc_d;
      seq_q    <= seq_d;
      conn_q   <= conn_d;
    end
  end

  // output register plus skid entry
  logic out_pop;
  assign out_pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_pop) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_pop) begin
      if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_q.kind;
  assign out_byte_o      = out_q.data;
  assign out_last_o      = out_q.last;
  assign out_seq_o       = out_q.seq;
  assign out_connected_o = out_q.connected;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while output register is empty");

  a_result_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result of a beat taken under stall was not kept");

  a_body_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpsd_pkg::PH_BODY) |-> (left_q != 16'd0))
    else $error("body phase with no bytes left");

  a_last_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (out_kind_o == lpsd_pkg::K_PAYLOAD))
    else $error("last flag on a non-payload result");

  a_accept_connects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == lpsd_pkg::K_ACCEPT) |-> out_connected_o)
    else $error("login accept reported while not connected");

endmodule

`default_nettype wire
